FILE: rtl/ppu_pkg.sv
`default_nettype none
package ppu_pkg;

   localparam int PATTERN_BYTES   = 8192;
   localparam int NAMETABLE_BYTES = 4096;
   localparam int PAT_AW          = $clog2(PATTERN_BYTES);
   localparam int NT_AW           = $clog2(NAMETABLE_BYTES);
   localparam int CLEAR_DEPTH     = (PATTERN_BYTES > NAMETABLE_BYTES) ?
                                    PATTERN_BYTES : NAMETABLE_BYTES;
   localparam int CLR_AW          = $clog2(CLEAR_DEPTH);

   localparam int ADDR_W = 14;
   localparam int DATA_W = 8;

   localparam logic [ADDR_W-1:0] PALETTE_BASE = 14'h3F00;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_RAISE = 2'd2;

   localparam logic [2:0] REG_CTRL0  = 3'd0;
   localparam logic [2:0] REG_CTRL1  = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   localparam logic [1:0] MIRROR_NONE       = 2'd0;
   localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
   localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
   localparam logic [1:0] MIRROR_FOUR       = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CTRL0_WR,
      OP_CTRL1_WR,
      OP_SCROLL_WR,
      OP_ADDR_WR,
      OP_DATA_WR,
      OP_STATUS_RD,
      OP_DATA_RD,
      OP_BUF_RD,
      OP_RAISE
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [DATA_W-1:0] data;
   } op_type;

   typedef struct packed {
      logic              wen;
      logic              ren;
      logic              is_nt;
      logic [PAT_AW-1:0] pat_idx;
      logic [NT_AW-1:0]  nt_idx;
      logic [DATA_W-1:0] wdata;
   } vram_cmd_type;

endpackage
`default_nettype wire

FILE: rtl/ppu_front.sv
`default_nettype none
module ppu_front (
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_action,
   input  wire logic [2:0]                req_reg_select,
   input  wire logic [ppu_pkg::DATA_W-1:0] req_write_data,
   input  wire logic                      clear_busy,
   input  wire logic                      queue_full,
   output logic                           push,
   output ppu_pkg::op_type                push_op
);

   ppu_pkg::op_kind_type kind;

   always_comb begin
      kind = ppu_pkg::OP_NONE;
      unique case (req_action)
         ppu_pkg::ACT_WRITE: begin
            unique case (req_reg_select)
               ppu_pkg::REG_CTRL0:  kind = ppu_pkg::OP_CTRL0_WR;
               ppu_pkg::REG_CTRL1:  kind = ppu_pkg::OP_CTRL1_WR;
               ppu_pkg::REG_SCROLL: kind = ppu_pkg::OP_SCROLL_WR;
               ppu_pkg::REG_ADDR:   kind = ppu_pkg::OP_ADDR_WR;
               ppu_pkg::REG_DATA:   kind = ppu_pkg::OP_DATA_WR;
               // status and object-RAM writes have no visible effect here
               default:             kind = ppu_pkg::OP_NONE;
            endcase
         end
         ppu_pkg::ACT_READ: begin
            unique case (req_reg_select)
               ppu_pkg::REG_STATUS: kind = ppu_pkg::OP_STATUS_RD;
               ppu_pkg::REG_DATA:   kind = ppu_pkg::OP_DATA_RD;
               default:             kind = ppu_pkg::OP_BUF_RD;
            endcase
         end
         ppu_pkg::ACT_RAISE: kind = ppu_pkg::OP_RAISE;
         default:            kind = ppu_pkg::OP_NONE;
      endcase
   end

   // hold off while video memory is being cleared or the queue has no room
   assign req_stall    = clear_busy | queue_full;
   assign push         = req_valid & ~req_stall;
   assign push_op.kind = kind;
   assign push_op.data = req_write_data;

endmodule
`default_nettype wire

FILE: rtl/ppu_queue.sv
`default_nettype none
module ppu_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire ppu_pkg::op_type push_op,
   input  wire logic            pop,
   output logic                 head_valid,
   output ppu_pkg::op_type      head_op,
   output logic                 full
);

   ppu_pkg::op_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head_valid = count_ff != 2'd0;
   assign head_op    = slot_ff[rd_ptr_ff];
   assign full       = count_ff == 2'd2;

endmodule
`default_nettype wire

FILE: rtl/ppu_vram.sv
`default_nettype none
module ppu_vram (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ppu_pkg::vram_cmd_type      cmd,
   output logic [ppu_pkg::DATA_W-1:0]      rdata,
   output logic                            clear_busy
);

   logic [ppu_pkg::DATA_W-1:0] pat_mem [ppu_pkg::PATTERN_BYTES];
   logic [ppu_pkg::DATA_W-1:0] nt_mem  [ppu_pkg::NAMETABLE_BYTES];
   logic [ppu_pkg::DATA_W-1:0] pat_q_ff;
   logic [ppu_pkg::DATA_W-1:0] nt_q_ff;
   logic                       sel_nt_ff;
   logic [ppu_pkg::CLR_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic                       busy_ff, busy_in;

   localparam logic [ppu_pkg::CLR_AW-1:0] CLR_LAST =
      ppu_pkg::CLR_AW'(ppu_pkg::CLEAR_DEPTH - 1);

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + ppu_pkg::CLR_AW'(1);
         if (clr_cnt_ff == CLR_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         busy_ff    <= 1'b1;
         sel_nt_ff  <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         busy_ff    <= busy_in;
         if (cmd.ren) begin
            sel_nt_ff <= cmd.is_nt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         pat_mem[clr_cnt_ff[ppu_pkg::PAT_AW-1:0]] <= '0;
      end else if (cmd.wen && !cmd.is_nt) begin
         pat_mem[cmd.pat_idx] <= cmd.wdata;
      end
      if (cmd.ren && !cmd.is_nt) begin
         pat_q_ff <= pat_mem[cmd.pat_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         nt_mem[clr_cnt_ff[ppu_pkg::NT_AW-1:0]] <= '0;
      end else if (cmd.wen && cmd.is_nt) begin
         nt_mem[cmd.nt_idx] <= cmd.wdata;
      end
      if (cmd.ren && cmd.is_nt) begin
         nt_q_ff <= nt_mem[cmd.nt_idx];
      end
   end

   assign rdata      = sel_nt_ff ? nt_q_ff : pat_q_ff;
   assign clear_busy = busy_ff;

endmodule
`default_nettype wire

FILE: rtl/ppu_back.sv
`default_nettype none
module ppu_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire ppu_pkg::op_type               head_op,
   output logic                               pop,
   input  wire logic [1:0]                    mirroring_mode,
   output ppu_pkg::vram_cmd_type              vram_cmd,
   input  wire logic [ppu_pkg::DATA_W-1:0]    vram_rdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ppu_pkg::DATA_W-1:0]         rsp_read_data,
   output logic [ppu_pkg::DATA_W-1:0]         rsp_control0,
   output logic [ppu_pkg::DATA_W-1:0]         rsp_control1,
   output logic [ppu_pkg::DATA_W-1:0]         rsp_scroll_x,
   output logic [ppu_pkg::DATA_W-1:0]         rsp_scroll_y,
   output logic [ppu_pkg::ADDR_W-1:0]         rsp_vram_address
);

   logic [ppu_pkg::DATA_W-1:0] ctrl0_ff, ctrl0_in;
   logic [ppu_pkg::DATA_W-1:0] ctrl1_ff, ctrl1_in;
   logic [ppu_pkg::DATA_W-1:0] scroll_x_ff, scroll_x_in;
   logic [ppu_pkg::DATA_W-1:0] scroll_y_ff, scroll_y_in;
   logic                       toggle_ff, toggle_in;
   logic [ppu_pkg::DATA_W-1:0] high_ff, high_in;
   logic [ppu_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic                       pending_ff, pending_in;
   logic                       buf_valid_ff, buf_valid_in;
   logic [ppu_pkg::DATA_W-1:0] status_ff, status_in;
   logic                       rsp_valid_ff;
   logic [ppu_pkg::DATA_W-1:0] rd_ff, rd_in;

   logic                       exec;
   logic [ppu_pkg::DATA_W-1:0] data;
   logic [ppu_pkg::DATA_W-1:0] buf_value;
   logic [ppu_pkg::ADDR_W-1:0] addr_step;
   logic [ppu_pkg::ADDR_W-1:0] target;
   logic [1:0]                 page;
   logic [11:0]                nt_full;
   logic [15:0]                loaded;

   assign exec      = head_valid & (~rsp_valid_ff | ~rsp_stall);
   assign pop       = exec;
   assign data      = head_op.data;
   // the read buffer lives in the memory output register once a fetch has run
   assign buf_value = buf_valid_ff ? vram_rdata : '0;
   assign addr_step = addr_ff + (ctrl0_ff[2] ? 14'd32 : 14'd1);
   assign loaded    = {high_ff, data};

   // a data read fetches at the stepped address unless an address load came first
   assign target = (head_op.kind == ppu_pkg::OP_DATA_RD && !pending_ff) ?
                   addr_step : addr_ff;

   always_comb begin
      unique case (mirroring_mode)
         ppu_pkg::MIRROR_HORIZONTAL: page = {1'b0, target[11]};
         ppu_pkg::MIRROR_VERTICAL:   page = {1'b0, target[10]};
         default:                    page = target[11:10];
      endcase
   end

   assign nt_full        = {page, target[9:0]};
   assign vram_cmd.is_nt = target[13];
   assign vram_cmd.pat_idx = target[ppu_pkg::PAT_AW-1:0];
   assign vram_cmd.nt_idx  = nt_full[ppu_pkg::NT_AW-1:0];
   assign vram_cmd.wdata   = data;
   // palette writes are not readable through this port; drop them
   assign vram_cmd.wen = exec && head_op.kind == ppu_pkg::OP_DATA_WR &&
                         addr_ff < ppu_pkg::PALETTE_BASE;
   assign vram_cmd.ren = exec && head_op.kind == ppu_pkg::OP_DATA_RD;

   always_comb begin
      ctrl0_in     = ctrl0_ff;
      ctrl1_in     = ctrl1_ff;
      scroll_x_in  = scroll_x_ff;
      scroll_y_in  = scroll_y_ff;
      toggle_in    = toggle_ff;
      high_in      = high_ff;
      addr_in      = addr_ff;
      pending_in   = pending_ff;
      buf_valid_in = buf_valid_ff;
      status_in    = status_ff;
      rd_in        = '0;
      unique case (head_op.kind)
         ppu_pkg::OP_CTRL0_WR: ctrl0_in = data;
         ppu_pkg::OP_CTRL1_WR: ctrl1_in = data;
         ppu_pkg::OP_SCROLL_WR: begin
            if (toggle_ff) begin
               scroll_y_in = data;
            end else begin
               scroll_x_in = data;
            end
            toggle_in = ~toggle_ff;
         end
         ppu_pkg::OP_ADDR_WR: begin
            if (toggle_ff) begin
               addr_in    = loaded[ppu_pkg::ADDR_W-1:0];
               pending_in = 1'b1;
            end else begin
               high_in = data;
            end
            toggle_in = ~toggle_ff;
         end
         ppu_pkg::OP_DATA_WR: addr_in = addr_step;
         ppu_pkg::OP_STATUS_RD: begin
            rd_in     = status_ff;
            toggle_in = 1'b0;
            status_in = {1'b0, status_ff[6:0]};
         end
         ppu_pkg::OP_DATA_RD: begin
            rd_in        = buf_value;
            addr_in      = target;
            pending_in   = 1'b0;
            buf_valid_in = 1'b1;
         end
         ppu_pkg::OP_BUF_RD: rd_in = buf_value;
         ppu_pkg::OP_RAISE:  status_in = status_ff | data;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff     <= '0;
         ctrl1_ff     <= '0;
         scroll_x_ff  <= '0;
         scroll_y_ff  <= '0;
         toggle_ff    <= 1'b0;
         high_ff      <= '0;
         addr_ff      <= '0;
         pending_ff   <= 1'b0;
         buf_valid_ff <= 1'b0;
         status_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec) begin
            ctrl0_ff     <= ctrl0_in;
            ctrl1_ff     <= ctrl1_in;
            scroll_x_ff  <= scroll_x_in;
            scroll_y_ff  <= scroll_y_in;
            toggle_ff    <= toggle_in;
            high_ff      <= high_in;
            addr_ff      <= addr_in;
            pending_ff   <= pending_in;
            buf_valid_ff <= buf_valid_in;
            status_ff    <= status_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rd_ff <= rd_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rd_ff;
   assign rsp_control0     = ctrl0_ff;
   assign rsp_control1     = ctrl1_ff;
   assign rsp_scroll_x     = scroll_x_ff;
   assign rsp_scroll_y     = scroll_y_ff;
   assign rsp_vram_address = addr_ff;

`ifndef SYNTHESIS
   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      !(vram_cmd.wen && vram_cmd.ren))
      else $error("video memory read and write in one cycle");

   a_addr_load_pending: assert property (@(posedge clock) disable iff (reset)
      (exec && head_op.kind == ppu_pkg::OP_ADDR_WR && toggle_ff) |=> pending_ff)
      else $error("address load did not arm the first-read skip");

   a_status_clear: assert property (@(posedge clock) disable iff (reset)
      (exec && head_op.kind == ppu_pkg::OP_STATUS_RD) |=> (!toggle_ff && !status_ff[7]))
      else $error("status read did not clear toggle and vblank");
`endif

endmodule
`default_nettype wire

FILE: rtl/ppu_register_port.sv
// Register port of a tile video processor, seen from the CPU bus.
// Request channel (req_*): one bus action per transfer: action 0 writes
// req_write_data to register req_reg_select, action 1 reads it, action 2
// ORs req_write_data into the status bits.
// Response channel (rsp_*): one transfer per request, in order, carrying the
// read byte (zero unless a read) and the control, scroll and address state
// after the action.
// Config channel (csr_*): the nametable mirroring mode; csr_ready is always
// high. Write it only while no request is outstanding.
// Flow: a request is stored in the queue, executes from its head, and its
// response is registered; rsp_stall holds it. The block takes one request per
// cycle while req_stall is low; a data read issues one synchronous video memory
// read whose result serves as the read buffer for later reads. A two-entry queue
// separates request decode from execution, so requests are still taken while a
// response waits on rsp_stall until the queue fills.
// Reset: synchronous, active high. After reset the pattern and nametable
// memories are cleared one address per cycle; req_stall stays high until
// all 8192 addresses of the larger memory have been cleared.
`default_nettype none
module ppu_register_port (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_action,
   input  wire logic [2:0]                 req_reg_select,
   input  wire logic [ppu_pkg::DATA_W-1:0] req_write_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [ppu_pkg::DATA_W-1:0]      rsp_read_data,
   output logic [ppu_pkg::DATA_W-1:0]      rsp_control0,
   output logic [ppu_pkg::DATA_W-1:0]      rsp_control1,
   output logic [ppu_pkg::DATA_W-1:0]      rsp_scroll_x,
   output logic [ppu_pkg::DATA_W-1:0]      rsp_scroll_y,
   output logic [ppu_pkg::ADDR_W-1:0]      rsp_vram_address,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [1:0]                 csr_mirroring_mode
);

   logic                  mode_write;
   logic [1:0]            mirroring_ff;
   logic                  clear_busy;
   logic                  queue_full;
   logic                  push;
   ppu_pkg::op_type       push_op;
   logic                  pop;
   logic                  head_valid;
   ppu_pkg::op_type       head_op;
   ppu_pkg::vram_cmd_type vram_cmd;
   logic [ppu_pkg::DATA_W-1:0] vram_rdata;

   assign csr_ready  = 1'b1;
   assign mode_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirroring_ff <= ppu_pkg::MIRROR_NONE;
      end else if (mode_write) begin
         mirroring_ff <= csr_mirroring_mode;
      end
   end

   ppu_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_reg_select (req_reg_select),
      .req_write_data (req_write_data),
      .clear_busy     (clear_busy),
      .queue_full     (queue_full),
      .push           (push),
      .push_op        (push_op)
   );

   ppu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op),
      .full       (queue_full)
   );

   ppu_vram u_vram (
      .clock      (clock),
      .reset      (reset),
      .cmd        (vram_cmd),
      .rdata      (vram_rdata),
      .clear_busy (clear_busy)
   );

   ppu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_op          (head_op),
      .pop              (pop),
      .mirroring_mode   (mirroring_ff),
      .vram_cmd         (vram_cmd),
      .vram_rdata       (vram_rdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_control0     (rsp_control0),
      .rsp_control1     (rsp_control1),
      .rsp_scroll_x     (rsp_scroll_x),
      .rsp_scroll_y     (rsp_scroll_y),
      .rsp_vram_address (rsp_vram_address)
   );

endmodule
`default_nettype wire
